### hw/rtl/gravity_force_accumulator_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the gravity force accumulator
// Shared implication forms, clocked on clk_i and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef GRAVITY_FORCE_ACCUMULATOR_DEFINES_SVH
`define GRAVITY_FORCE_ACCUMULATOR_DEFINES_SVH

// same-cycle implication
`define GFA_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("gfa assertion failed");

// next-cycle implication
`define GFA_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("gfa assertion failed");

`endif

### hw/rtl/gfa_pkg.sv
// ----------------------------------------------------------------------------
// gfa_pkg
// Types and constants of the gravity force accumulator.
// ----------------------------------------------------------------------------
package gfa_pkg;

  typedef struct packed {
    logic signed [31:0] query_x;
    logic signed [31:0] query_y;
    logic signed [31:0] query_z;
    logic signed [31:0] source_x;
    logic signed [31:0] source_y;
    logic signed [31:0] source_z;
    logic        [31:0] source_mass;
    logic               last_body;
  } in_word_t;

  typedef struct packed {
    logic signed [63:0] force_x;
    logic signed [63:0] force_y;
    logic signed [63:0] force_z;
  } out_word_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SQ,
    ST_EPS,
    ST_SQRT,
    ST_MUL,
    ST_DIV1,
    ST_DIV2,
    ST_ACC,
    ST_FIN
  } state_e;

  localparam logic [31:0] SOFTENING_RESET = 32'd1;
  localparam logic [63:0] MAG_MAX         = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] SUM_MIN         = 64'h8000_0000_0000_0000;
  localparam logic [63:0] SQRT_BIT_INIT   = 64'h4000_0000_0000_0000;
  localparam logic [1:0]  AXIS_LAST       = 2'd2;
  localparam logic        REG_SOFTENING   = 1'b0;

endpackage

### hw/rtl/gfa_div.sv
// ----------------------------------------------------------------------------
// gfa_div
// Restoring divider, 128-bit dividend by 64-bit divisor, one bit per cycle.
// ----------------------------------------------------------------------------
module gfa_div (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         start_i,
  input  logic [127:0] num_i,
  input  logic [63:0]  den_i,
  output logic         done_o,
  output logic [127:0] quo_o
);

  logic         busy_q, busy_d;
  logic         done_q, done_d;
  logic [6:0]   cnt_q, cnt_d;
  logic [127:0] n_q, n_d;
  logic [63:0]  rem_q, rem_d;
  logic [63:0]  den_q, den_d;
  logic [64:0]  rem_sh;
  logic         ge;

  assign rem_sh = {rem_q, n_q[127]};
  assign ge     = rem_sh >= {1'b0, den_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    n_d    = n_q;
    rem_d  = rem_q;
    den_d  = den_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      n_d    = num_i;
      rem_d  = '0;
      den_d  = den_i;
    end else if (busy_q) begin
      n_d   = {n_q[126:0], ge};
      rem_d = ge ? 64'(rem_sh - {1'b0, den_q}) : rem_sh[63:0];
      cnt_d = 7'(cnt_q + 7'd1);
      if (cnt_q == 7'd127) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    n_q   <= n_d;
    rem_q <= rem_d;
    den_q <= den_d;
  end

  assign done_o = done_q;
  assign quo_o  = n_q;

endmodule

### hw/rtl/gravity_force_accumulator.sv
// Work per word: 3 squares, 1 softening add, 32 square root steps, then
// per axis 1 multiply and two 128-step divisions.
// An axis with zero difference or zero distance skips both divisions.
// Input stalls outside idle: no new word is taken before the last is done.
// Reset: sums clear to zero, softening to 1, output empty.
// ----------------------------------------------------------------------------
// gravity_force_accumulator
// Softened gravity force sum over source bodies with one shared multiplier.
// ----------------------------------------------------------------------------
`include "gravity_force_accumulator_defines.svh"

module gravity_force_accumulator (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  gfa_pkg::in_word_t  in_word_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output gfa_pkg::out_word_t out_word_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  import gfa_pkg::*;

  state_e             state_q, state_d;
  logic [31:0]        soft_q;
  logic signed [32:0] dx_q, dy_q, dz_q, dcur;
  logic [31:0]        mass_q, mag;
  logic               last_q, last_d;
  logic [1:0]         axis_q, axis_d;
  logic [63:0]        s_q, s_d, xr_q, xr_d, res_q, res_d, bit_q, bit_d;
  logic [63:0]        sqt, prod, sadd_a, sadd_b, sadd;
  logic [64:0]        sadd_w;
  logic [31:0]        mul_b;
  logic [63:0]        con_q, con_d, cmag;
  logic [63:0]        sx_q, sy_q, sz_q, sx_d, sy_d, sz_d, scur, acc;
  logic               div_start, div_done;
  logic [127:0]       div_num, div_quo;
  logic [63:0]        div_den;
  logic               out_valid_q, out_valid_d, out_free, accept;
  out_word_t          out_q, out_d;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_SOFTENING) ? soft_q : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      soft_q <= SOFTENING_RESET;
    end else if (psel && penable && pwrite && paddr[2] == REG_SOFTENING) begin
      soft_q <= pwdata;
    end
  end

  assign accept   = in_valid_i && !in_stall_o;
  assign in_stall_o = state_q != ST_IDLE;
  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    case (axis_q)
      2'd0:    begin dcur = dx_q; scur = sx_q; end
      2'd1:    begin dcur = dy_q; scur = sy_q; end
      default: begin dcur = dz_q; scur = sz_q; end
    endcase
  end
  assign mag = dcur[32] ? 32'(-dcur) : dcur[31:0];

  // shared multiplier
  assign mul_b = (state_q == ST_SQ) ? mag : mass_q;
  assign prod  = 64'(mag) * 64'(mul_b);

  // shared unsigned saturating adder
  assign sadd_a = s_q;
  assign sadd_b = (state_q == ST_EPS) ? {32'd0, soft_q} : prod;
  assign sadd_w = {1'b0, sadd_a} + {1'b0, sadd_b};
  assign sadd   = sadd_w[64] ? '1 : sadd_w[63:0];

  assign sqt = res_q + bit_q;

  assign cmag = (div_quo[127:63] != '0) ? MAG_MAX : div_quo[63:0];

  always_comb begin
    logic [63:0] sum_w;
    sum_w = scur + con_q;
    if (scur[63] == con_q[63] && sum_w[63] != scur[63]) begin
      acc = scur[63] ? SUM_MIN : MAG_MAX;
    end else begin
      acc = sum_w;
    end
  end

  always_comb begin
    state_d     = state_q;
    last_d      = last_q;
    axis_d      = axis_q;
    s_d         = s_q;
    xr_d        = xr_q;
    res_d       = res_q;
    bit_d       = bit_q;
    con_d       = con_q;
    sx_d        = sx_q;
    sy_d        = sy_q;
    sz_d        = sz_q;
    div_start   = 1'b0;
    div_num     = {24'd0, prod, 40'd0};
    div_den     = s_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_d       = out_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          last_d  = in_word_i.last_body;
          axis_d  = '0;
          state_d = ST_SQ;
        end
      end
      ST_SQ: begin
        s_d = (axis_q == 2'd0) ? prod : sadd;
        if (axis_q == AXIS_LAST) begin
          state_d = ST_EPS;
        end else begin
          axis_d = 2'(axis_q + 2'd1);
        end
      end
      ST_EPS: begin
        s_d     = sadd;
        xr_d    = sadd;
        res_d   = '0;
        bit_d   = SQRT_BIT_INIT;
        state_d = ST_SQRT;
      end
      ST_SQRT: begin
        if (xr_q >= sqt) begin
          xr_d  = xr_q - sqt;
          res_d = (res_q >> 1) + bit_q;
        end else begin
          res_d = res_q >> 1;
        end
        bit_d = bit_q >> 2;
        if (bit_q[0]) begin
          axis_d  = '0;
          state_d = ST_MUL;
        end
      end
      ST_MUL: begin
        if (mag == '0 || s_q == '0) begin
          con_d   = '0;
          state_d = ST_ACC;
        end else begin
          div_start = 1'b1;
          state_d   = ST_DIV1;
        end
      end
      ST_DIV1: begin
        if (div_done) begin
          div_start = 1'b1;
          div_num   = div_quo;
          div_den   = res_q;
          state_d   = ST_DIV2;
        end
      end
      ST_DIV2: begin
        if (div_done) begin
          con_d   = dcur[32] ? 64'(-cmag) : cmag;
          state_d = ST_ACC;
        end
      end
      ST_ACC: begin
        case (axis_q)
          2'd0:    sx_d = acc;
          2'd1:    sy_d = acc;
          default: sz_d = acc;
        endcase
        if (axis_q == AXIS_LAST) begin
          state_d = ST_FIN;
        end else begin
          axis_d  = 2'(axis_q + 2'd1);
          state_d = ST_MUL;
        end
      end
      ST_FIN: begin
        if (!last_q) begin
          state_d = ST_IDLE;
        end else if (out_free) begin
          out_valid_d   = 1'b1;
          out_d.force_x = sx_q;
          out_d.force_y = sy_q;
          out_d.force_z = sz_q;
          sx_d          = '0;
          sy_d          = '0;
          sz_d          = '0;
          state_d       = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      sx_q        <= '0;
      sy_q        <= '0;
      sz_q        <= '0;
      axis_q      <= '0;
      last_q      <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      sx_q        <= sx_d;
      sy_q        <= sy_d;
      sz_q        <= sz_d;
      axis_q      <= axis_d;
      last_q      <= last_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      dx_q   <= 33'(in_word_i.source_x) - 33'(in_word_i.query_x);
      dy_q   <= 33'(in_word_i.source_y) - 33'(in_word_i.query_y);
      dz_q   <= 33'(in_word_i.source_z) - 33'(in_word_i.query_z);
      mass_q <= in_word_i.source_mass;
    end
    s_q   <= s_d;
    xr_q  <= xr_d;
    res_q <= res_d;
    bit_q <= bit_d;
    con_q <= con_d;
    out_q <= out_d;
  end

  gfa_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

  `GFA_ASSERT_NEXT(a_accept_busy, accept, state_q == ST_SQ)
  `GFA_ASSERT_NEXT(a_out_from_fin, !out_valid_q && out_valid_d, $past(state_q) == ST_FIN)
  `GFA_ASSERT_IMPL(a_div_done_wait, div_done, state_q == ST_DIV1 || state_q == ST_DIV2)

endmodule
